// ----- sv/hdrtm_pkg.sv -----
`timescale 1ns / 1ps
package hdrtm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int VAL_W = 24;
	localparam int EXP_W = 24;
	localparam int GAM_W = 20;
	localparam int BYTE_W = 8;
	localparam int IQ = 30;
	localparam int XW = FRAC_BITS + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	localparam longint unsigned EXPOSURE_RST = 65536;
	localparam longint unsigned INV_GAMMA_RST = 29789;

	// ACES fit coefficients, rounded to nearest at FRAC_BITS fractional bits.
	localparam int KC_W = FRAC_BITS + 2;
	localparam logic [KC_W-1:0] ACES_A = KC_W'((251 * ONE + 50) / 100);
	localparam logic [KC_W-1:0] ACES_B = KC_W'((3 * ONE + 50) / 100);
	localparam logic [KC_W-1:0] ACES_C = KC_W'((243 * ONE + 50) / 100);
	localparam logic [KC_W-1:0] ACES_D = KC_W'((59 * ONE + 50) / 100);
	localparam logic [KC_W-1:0] ACES_E = KC_W'((14 * ONE + 50) / 100);

	localparam int PW = VAL_W + 2;
	localparam int DW = 2 * VAL_W + 3;
	localparam int K_W = $clog2(FRAC_BITS + 1);
	localparam int LG_W = FRAC_BITS + K_W;
	localparam int P_W = LG_W + GAM_W - FRAC_BITS;
	localparam int N_W = P_W - FRAC_BITS;
	localparam int SHIFT_LIM = 32;

	localparam int TONE_LAT = FRAC_BITS + 3;
	localparam int POW_LAT = 2 * FRAC_BITS + 3;
	localparam int PIPE_LAT = 1 + TONE_LAT + POW_LAT;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_GAMMA = 2'd2;

	typedef enum logic [1:0] {
		TM_NONE = 2'd0,
		TM_REINHARD = 2'd1,
		TM_ACES = 2'd2,
		TM_HABLE = 2'd3
	} tone_mode_t;

	function automatic logic [XW-1:0] clamp_one(input logic [VAL_W-1:0] v);
		if (v >= VAL_W'(ONE)) begin
			return XW'(ONE);
		end
		return v[XW-1:0];
	endfunction

	function automatic logic [BYTE_W-1:0] to_byte(input logic [XW-1:0] v);
		logic [XW+BYTE_W-1:0] p;
		p = {v, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, v};
		return p[FRAC_BITS +: BYTE_W];
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] vv;
		r = '0;
		b = 64'd1 << 62;
		vv = v;
		for (int i = 0; i < 32; i++) begin
			if (b > vv) begin
				b = b >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (vv >= r + b) begin
					vv = vv - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// Factor 2^(-2^-idx) at IQ fractional bits, by repeated square roots.
	function automatic logic [IQ-1:0] exp_root(input int idx);
		logic [63:0] t;
		t = 64'd1 << IQ;
		for (int j = 1; j <= idx; j++) begin
			t = isqrt64(t << IQ);
			if (j == 1) begin
				t = isqrt64(64'd1 << (2 * IQ - 1));
			end
		end
		return t[IQ-1:0];
	endfunction

endpackage

// ----- sv/hdrtm_pix_in_if.sv -----
`timescale 1ns / 1ps
interface hdrtm_pix_in_if;
	import hdrtm_pkg::*;

	logic valid;
	logic ready;
	logic [VAL_W-1:0] red_in;
	logic [VAL_W-1:0] green_in;
	logic [VAL_W-1:0] blue_in;
	logic [VAL_W-1:0] alpha_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// ----- sv/hdrtm_pix_out_if.sv -----
`timescale 1ns / 1ps
interface hdrtm_pix_out_if;
	import hdrtm_pkg::*;

	logic valid;
	logic ready;
	logic [BYTE_W-1:0] red_byte;
	logic [BYTE_W-1:0] green_byte;
	logic [BYTE_W-1:0] blue_byte;
	logic [BYTE_W-1:0] alpha_byte;

	modport source (output valid, red_byte, green_byte, blue_byte, alpha_byte, input ready);
	modport sink (input valid, red_byte, green_byte, blue_byte, alpha_byte, output ready);
endinterface

// ----- sv/hdrtm_tone.sv -----
`timescale 1ns / 1ps
module hdrtm_tone (
	input logic clk,
	input logic en,
	input hdrtm_pkg::tone_mode_t mode,
	input logic [hdrtm_pkg::VAL_W-1:0] val,
	output logic [hdrtm_pkg::XW-1:0] tone
);
	import hdrtm_pkg::*;

	localparam int NSTG = FRAC_BITS;
	localparam int MW = VAL_W + KC_W;

	logic [MW-1:0] ma;
	logic [MW-1:0] mc;
	logic [VAL_W-1:0] c_s1;
	tone_mode_t mode_s1;
	logic [PW-1:0] pa_s1;
	logic [PW-1:0] pc_s1;
	logic [DW-1:0] nm;
	logic [DW-1:0] dn;

	logic [VAL_W-1:0] c_sd [0:NSTG];
	tone_mode_t mode_sd [0:NSTG];
	logic [DW-1:0] rem_sd [0:NSTG-1];
	logic [DW-1:0] den_sd [0:NSTG-1];
	logic [FRAC_BITS-1:0] quo_sd [1:NSTG];
	logic ge_sd [1:NSTG];
	logic [XW-1:0] tone_d;

	always_comb begin
		ma = MW'(val) * MW'(ACES_A);
		mc = MW'(val) * MW'(ACES_C);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= val;
			mode_s1 <= mode;
			pa_s1 <= PW'(ma >> FRAC_BITS) + PW'(ACES_B);
			pc_s1 <= PW'(mc >> FRAC_BITS) + PW'(ACES_D);
		end
	end

	always_comb begin
		nm = DW'(c_s1) * DW'(pa_s1);
		dn = DW'(c_s1) * DW'(pc_s1) + (DW'(ACES_E) << FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_sd[0] <= c_s1;
			mode_sd[0] <= mode_s1;
			if (mode_s1 == TM_REINHARD) begin
				rem_sd[0] <= DW'(c_s1);
				den_sd[0] <= DW'(c_s1) + DW'(ONE);
			end else begin
				rem_sd[0] <= nm;
				den_sd[0] <= dn;
			end
		end
	end

	// Restoring division, one quotient bit per stage.
	for (genvar j = 1; j <= NSTG; j++) begin : g_div
		logic [DW:0] sh;
		logic fit;

		always_comb begin
			sh = {rem_sd[j-1], 1'b0};
			fit = sh >= {1'b0, den_sd[j-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_sd[j] <= c_sd[j-1];
				mode_sd[j] <= mode_sd[j-1];
			end
		end

		if (j < NSTG) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_sd[j] <= fit ? DW'(sh - {1'b0, den_sd[j-1]}) : sh[DW-1:0];
					den_sd[j] <= den_sd[j-1];
				end
			end
		end

		if (j == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					quo_sd[j] <= {{(FRAC_BITS-1){1'b0}}, fit};
					ge_sd[j] <= rem_sd[0] >= den_sd[0];
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					quo_sd[j] <= {quo_sd[j-1][FRAC_BITS-2:0], fit};
					ge_sd[j] <= ge_sd[j-1];
				end
			end
		end
	end

	always_comb begin
		case (mode_sd[NSTG]) inside
			TM_NONE: tone_d = clamp_one(c_sd[NSTG]);
			TM_REINHARD: tone_d = XW'(quo_sd[NSTG]);
			TM_ACES, TM_HABLE: tone_d = ge_sd[NSTG] ? XW'(ONE) : XW'(quo_sd[NSTG]);
			default: tone_d = XW'(ONE);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tone <= tone_d;
		end
	end

endmodule

// ----- sv/hdrtm_pow.sv -----
`timescale 1ns / 1ps
module hdrtm_pow (
	input logic clk,
	input logic en,
	input logic [hdrtm_pkg::GAM_W-1:0] gamma,
	input logic [hdrtm_pkg::XW-1:0] lin,
	output logic [hdrtm_pkg::BYTE_W-1:0] pix_byte
);
	import hdrtm_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int LAST = 2 * F + 1;
	localparam int MSW = IQ + 1;
	localparam int SQW = 2 * MSW;
	localparam int LPW = LG_W + GAM_W;
	localparam int AW = IQ + 1;
	localparam int APW = AW + IQ;

	logic [F-1:0] xl;
	logic [K_W-1:0] msb;
	logic [F-1:0] xn;

	logic one_sd [0:LAST];
	logic zero_sd [0:LAST];
	logic [MSW-1:0] m_sd [0:F-1];
	logic [F-1:0] frac_sd [0:F];
	logic [K_W-1:0] k_sd [0:F];
	logic [F-1:0] f_sd [F+1:2*F];
	logic [N_W-1:0] n_sd [F+1:LAST];
	logic [AW-1:0] acc_sd [F+1:LAST];

	logic [LG_W-1:0] lg;
	logic [LPW-1:0] lp;
	logic [F:0] amant;
	logic [F:0] shv;
	logic [XW-1:0] res;

	always_comb begin
		xl = lin[F-1:0];
		msb = '0;
		for (int i = 0; i < F; i++) begin
			if (xl[i]) begin
				msb = K_W'(i);
			end
		end
		xn = xl << (K_W'(F - 1) - msb);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_sd[0] <= {xn, {(MSW-F){1'b0}}};
			k_sd[0] <= K_W'(F) - msb;
			frac_sd[0] <= '0;
			one_sd[0] <= (gamma == '0) || (lin >= XW'(ONE));
			zero_sd[0] <= lin == '0;
		end
	end

	for (genvar s = 1; s <= LAST; s++) begin : g_flag
		always_ff @(posedge clk) begin
			if (en) begin
				one_sd[s] <= one_sd[s-1];
				zero_sd[s] <= zero_sd[s-1];
			end
		end
	end

	// log2 by repeated squaring, one fraction bit per stage.
	for (genvar j = 1; j <= F; j++) begin : g_log
		logic [SQW-1:0] sq;
		logic [MSW:0] mn;
		logic hi;

		always_comb begin
			sq = SQW'(m_sd[j-1]) * SQW'(m_sd[j-1]);
			mn = sq[IQ +: MSW+1];
			hi = mn[MSW];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				frac_sd[j] <= {frac_sd[j-1][F-2:0], hi};
				k_sd[j] <= k_sd[j-1];
			end
		end

		if (j < F) begin : g_m
			always_ff @(posedge clk) begin
				if (en) begin
					m_sd[j] <= hi ? mn[MSW:1] : mn[MSW-1:0];
				end
			end
		end
	end

	always_comb begin
		lg = (LG_W'(k_sd[F]) << F) - LG_W'(frac_sd[F]);
		lp = LPW'(lg) * LPW'(gamma);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_sd[F+1] <= lp[F +: F];
			n_sd[F+1] <= lp[2*F +: N_W];
			acc_sd[F+1] <= AW'(64'd1 << IQ);
		end
	end

	// exp2 of the fraction, one constant factor per stage.
	for (genvar i = 1; i <= F; i++) begin : g_exp
		localparam logic [IQ-1:0] ROOT = exp_root(i);
		logic [APW-1:0] prod;

		always_comb begin
			prod = APW'(acc_sd[F+i]) * APW'(ROOT);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_sd[F+1+i] <= n_sd[F+i];
				acc_sd[F+1+i] <= f_sd[F+i][F-i] ? prod[IQ +: AW] : acc_sd[F+i];
			end
		end

		if (i < F) begin : g_f
			always_ff @(posedge clk) begin
				if (en) begin
					f_sd[F+1+i] <= f_sd[F+i];
				end
			end
		end
	end

	always_comb begin
		amant = acc_sd[LAST][IQ-F +: F+1];
		shv = (n_sd[LAST] < N_W'(SHIFT_LIM)) ? (amant >> n_sd[LAST]) : '0;
		if (one_sd[LAST]) begin
			res = XW'(ONE);
		end else if (zero_sd[LAST]) begin
			res = '0;
		end else begin
			res = shv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_byte <= to_byte(res);
		end
	end

endmodule

// ----- sv/hdr_tone_map_to_rgba8_core.sv -----
`timescale 1ns / 1ps
// HDR to RGBA8 tone mapper. One pixel is taken and one is given on every clock while the
// output is not held; the pipeline is an exposure multiply, 19 tone map stages with a
// 16-step divider and 35 power stages with 16 log2 and 16 exp2 steps. The whole pipeline
// holds while a finished pixel waits at the output, and moves on as soon as it is taken.
// Configuration must be written while no pixel is in flight; the block does not check.
module hdr_tone_map_to_rgba8_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [hdrtm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hdrtm_pkg::CFG_DATA_W-1:0] cfg_data,
	hdrtm_pix_in_if.sink pix_in,
	hdrtm_pix_out_if.source pix_out
);
	import hdrtm_pkg::*;

	localparam int PW2 = VAL_W + EXP_W;

	logic [EXP_W-1:0] exposure_q;
	tone_mode_t tone_mode_q;
	logic [GAM_W-1:0] inv_gamma_q;

	logic en;
	logic vld_s [0:PIPE_LAT-1];
	logic [VAL_W-1:0] chan_in [4];
	logic [PW2-1:0] prod [4];
	logic [VAL_W-1:0] expo_d [4];
	logic [VAL_W-1:0] expo_s1 [4];
	logic [BYTE_W-1:0] alpha_s [0:PIPE_LAT-2];
	logic [XW-1:0] tone_x [3];
	logic [BYTE_W-1:0] col_byte [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exposure_q <= EXP_W'(EXPOSURE_RST);
			tone_mode_q <= TM_NONE;
			inv_gamma_q <= GAM_W'(INV_GAMMA_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXPOSURE: exposure_q <= cfg_data[EXP_W-1:0];
				CFG_TONE_MODE: tone_mode_q <= tone_mode_t'(cfg_data[1:0]);
				CFG_INV_GAMMA: inv_gamma_q <= cfg_data[GAM_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !vld_s[PIPE_LAT-1] || pix_out.ready;
	assign pix_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= pix_in.valid;
			for (int i = 1; i < PIPE_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	assign chan_in[0] = pix_in.red_in;
	assign chan_in[1] = pix_in.green_in;
	assign chan_in[2] = pix_in.blue_in;
	assign chan_in[3] = pix_in.alpha_in;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			prod[c] = PW2'(chan_in[c]) * PW2'(exposure_q);
			if (|prod[c][PW2-1:VAL_W+FRAC_BITS]) begin
				expo_d[c] = VAL_MAX;
			end else begin
				expo_d[c] = prod[c][FRAC_BITS +: VAL_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				expo_s1[c] <= expo_d[c];
			end
			alpha_s[0] <= to_byte(clamp_one(expo_s1[3]));
			for (int i = 1; i < PIPE_LAT - 1; i++) begin
				alpha_s[i] <= alpha_s[i-1];
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_col
		hdrtm_tone u_tone (
			.clk (clk),
			.en (en),
			.mode (tone_mode_q),
			.val (expo_s1[c]),
			.tone (tone_x[c])
		);

		hdrtm_pow u_pow (
			.clk (clk),
			.en (en),
			.gamma (inv_gamma_q),
			.lin (tone_x[c]),
			.pix_byte (col_byte[c])
		);
	end

	assign pix_out.valid = vld_s[PIPE_LAT-1];
	assign pix_out.red_byte = col_byte[0];
	assign pix_out.green_byte = col_byte[1];
	assign pix_out.blue_byte = col_byte[2];
	assign pix_out.alpha_byte = alpha_s[PIPE_LAT-2];

endmodule

// ----- verif/hdrtm_checker.sv -----
`timescale 1ns / 1ps
module hdrtm_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [hdrtm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hdrtm_pkg::CFG_DATA_W-1:0] cfg_data,
	hdrtm_pix_in_if.sink pix_in,
	hdrtm_pix_out_if.sink pix_out,
	output int fail_count,
	output int pixels_out,
	output int pending
);
	import hdrtm_pkg::*;

	localparam longint unsigned K_A = (251 * ONE + 50) / 100;
	localparam longint unsigned K_B = (3 * ONE + 50) / 100;
	localparam longint unsigned K_C = (243 * ONE + 50) / 100;
	localparam longint unsigned K_D = (59 * ONE + 50) / 100;
	localparam longint unsigned K_E = (14 * ONE + 50) / 100;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba8_t;

	logic [23:0] gain;
	tone_mode_t mode;
	logic [19:0] gamma_exp;
	rgba8_t expected_pixels[$];
	longint unsigned gamma_roots[1:FRAC_BITS];

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned fixed_div(longint unsigned num, longint unsigned den);
		longint unsigned r, q;
		r = num;
		q = 0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= den) begin
				r -= den;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned aces_curve(longint unsigned c);
		longint unsigned num, den;
		num = c * (((K_A * c) >> FRAC_BITS) + K_B);
		den = c * (((K_C * c) >> FRAC_BITS) + K_D) + (K_E << FRAC_BITS);
		if (num >= den) return ONE;
		return fixed_div(num, den);
	endfunction

	function automatic longint unsigned gamma_pow(longint unsigned x, longint unsigned g);
		longint unsigned m, fr, lg, p, n, f, acc;
		int k;
		fr = 0;
		k = 0;
		if (g == 0 || x >= ONE) return ONE;
		if (x == 0) return 0;
		m = x << (IQ - FRAC_BITS);
		while (m < (64'd1 << IQ)) begin
			m <<= 1;
			k++;
		end
		for (int i = 0; i < FRAC_BITS; i++) begin
			m = (m * m) >> IQ;
			fr <<= 1;
			if (m >= (64'd2 << IQ)) begin
				m >>= 1;
				fr |= 1;
			end
		end
		lg = (longint'(k) << FRAC_BITS) - fr;
		p = (lg * g) >> FRAC_BITS;
		n = p >> FRAC_BITS;
		f = p & (ONE - 1);
		acc = 64'd1 << IQ;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			if ((f >> (FRAC_BITS - i)) & 1) acc = (acc * gamma_roots[i]) >> IQ;
		end
		acc >>= (IQ - FRAC_BITS);
		if (n >= 32) return 0;
		return acc >> n;
	endfunction

	function automatic logic [7:0] channel_byte(logic [23:0] raw, bit colour);
		longint unsigned v;
		v = (longint'(raw) * gain) >> FRAC_BITS;
		if (v > 64'hFFFFFF) v = 64'hFFFFFF;
		if (colour) begin
			if (mode == TM_REINHARD) v = fixed_div(v, v + ONE);
			else if (mode == TM_ACES || mode == TM_HABLE) v = aces_curve(v);
			v = gamma_pow(v > ONE ? ONE : v, gamma_exp);
		end
		if (v > ONE) v = ONE;
		return 8'((v * 255) >> FRAC_BITS);
	endfunction

	initial begin
		longint unsigned t;
		t = 64'd1 << IQ;
		for (int i = 1; i <= FRAC_BITS; i++) begin
			t = int_sqrt(t << IQ);
			if (i == 1) t = int_sqrt(64'd1 << (2 * IQ - 1));
			gamma_roots[i] = t;
		end
	end

	assign pending = expected_pixels.size();

	always @(posedge clk or negedge arst_n) begin
		rgba8_t e;
		if (!arst_n) begin
			gain <= 24'(EXPOSURE_RST);
			mode <= TM_NONE;
			gamma_exp <= 20'(INV_GAMMA_RST);
			fail_count <= 0;
			pixels_out <= 0;
			expected_pixels.delete();
		end else begin
			if (pix_in.valid && pix_in.ready) begin
				e.r = channel_byte(pix_in.red_in, 1'b1);
				e.g = channel_byte(pix_in.green_in, 1'b1);
				e.b = channel_byte(pix_in.blue_in, 1'b1);
				e.a = channel_byte(pix_in.alpha_in, 1'b0);
				expected_pixels = {expected_pixels, e};
			end
			if (pix_out.valid && pix_out.ready) begin
				pixels_out <= pixels_out + 1;
				if (expected_pixels.size() == 0) begin
					$error("unexpected output item");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_pixels.pop_front();
					if ({pix_out.red_byte, pix_out.green_byte, pix_out.blue_byte,
						pix_out.alpha_byte} !== e) begin
						if (pix_out.red_byte !== e.r)
							$error("red_byte expected %0d got %0d", e.r, pix_out.red_byte);
						if (pix_out.green_byte !== e.g)
							$error("green_byte expected %0d got %0d", e.g, pix_out.green_byte);
						if (pix_out.blue_byte !== e.b)
							$error("blue_byte expected %0d got %0d", e.b, pix_out.blue_byte);
						if (pix_out.alpha_byte !== e.a)
							$error("alpha_byte expected %0d got %0d", e.a, pix_out.alpha_byte);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_EXPOSURE: gain <= cfg_data[23:0];
					CFG_TONE_MODE: mode <= tone_mode_t'(cfg_data[1:0]);
					CFG_INV_GAMMA: gamma_exp <= cfg_data[19:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import hdrtm_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int fail_count, pixels_out, pending;
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_recv = 0;
	int quiet_cycles = 0;
	int pixels_in = 0;

	hdrtm_pix_in_if pix_in ();
	hdrtm_pix_out_if pix_out ();

	hdr_tone_map_to_rgba8_core u_top (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.pix_in(pix_in.sink), .pix_out(pix_out.source));

	hdrtm_checker u_checker (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.pix_in(pix_in.sink), .pix_out(pix_out.sink), .fail_count, .pixels_out, .pending);

	always #1 clk = ~clk;

	initial begin
		pix_in.valid = 0;
		pix_in.red_in = 0;
		pix_in.green_in = 0;
		pix_in.blue_in = 0;
		pix_in.alpha_in = 0;
		pix_out.ready = 0;
	end

	always @(negedge clk) begin
		pix_out.ready <= !hold_recv && arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (pix_in.valid && pix_in.ready) pixels_in <= pixels_in + 1;
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b, logic [23:0] a);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		pix_in.valid = 1;
		pix_in.red_in = r;
		pix_in.green_in = g;
		pix_in.blue_in = b;
		pix_in.alpha_in = a;
		do @(posedge clk); while (!pix_in.ready);
		@(negedge clk);
		pix_in.valid = 0;
	endtask

	task automatic drain;
		while (pending != 0) @(negedge clk);
		repeat (PIPE_LAT + 5) @(negedge clk);
	endtask

	function automatic logic [23:0] rand_value();
		case ($urandom_range(4))
			0: return 24'($urandom_range(65536));
			1: return 24'($urandom_range(4096));
			2: return 24'($urandom);
			3: return 24'($urandom_range(300000));
			default: return $urandom_range(1) ? 24'hFFFFFF : 24'd0;
		endcase
	endfunction

	task automatic random_pixels(int count);
		for (int i = 0; i < count; i++)
			send_pixel(rand_value(), rand_value(), rand_value(), rand_value());
	endtask

	initial begin
		logic [23:0] edges[6];
		edges = '{24'd0, 24'd1, 24'h8000, 24'h10000, 24'h10001, 24'hFFFFFF};
		repeat (2) @(negedge clk);
		arst_n = 1;
		// Directed pixels under the reset settings and a few extremes.
		for (int i = 0; i < 6; i++) send_pixel(edges[i], edges[5 - i], 24'h5555AA, edges[i]);
		send_pixel(24'hAAAA55, 24'h123456, 24'h000100, 24'h00FFFF);
		drain();
		write_reg(CFG_EXPOSURE, 24'hFFFFFF);
		write_reg(CFG_TONE_MODE, CFG_DATA_W'(TM_REINHARD));
		write_reg(CFG_INV_GAMMA, 24'd0);
		for (int i = 0; i < 6; i++) send_pixel(edges[i], edges[i], edges[5 - i], edges[i]);
		drain();
		write_reg(CFG_EXPOSURE, 24'd0);
		write_reg(CFG_TONE_MODE, CFG_DATA_W'(TM_ACES));
		write_reg(CFG_INV_GAMMA, 24'hFFFFF);
		send_pixel(24'h10000, 24'h0, 24'hFFFFFF, 24'h10000);
		drain();
		write_reg(CFG_EXPOSURE, 24'h10000);
		write_reg(CFG_INV_GAMMA, 24'hFFFFF);
		for (int i = 0; i < 6; i++) send_pixel(edges[i], 24'h00_0800, 24'h00_F000, edges[i]);
		drain();
		write_reg(CFG_TONE_MODE, CFG_DATA_W'(TM_HABLE));
		write_reg(CFG_INV_GAMMA, 24'd1);
		send_pixel(24'h1, 24'h8000, 24'h20000, 24'h7FFF);
		drain();
		// Long receiver hold-off while the sender keeps offering pixels.
		hold_recv = 1;
		fork
			random_pixels(80);
			begin
				repeat (300) @(negedge clk);
				hold_recv = 0;
			end
		join
		drain();
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = phase == 0 ? 14 : phase == 1 ? 77 : 0;
			recv_idle_pct = phase == 0 ? 77 : phase == 1 ? 14 : 0;
			for (int s = 0; s < 4; s++) begin
				write_reg(CFG_EXPOSURE, 24'($urandom_range(4)) == 0 ? 24'($urandom)
					: 24'($urandom_range(8 << 16)));
				write_reg(CFG_TONE_MODE, CFG_DATA_W'(2'($urandom_range(3))));
				write_reg(CFG_INV_GAMMA, CFG_DATA_W'(20'($urandom_range(3)) == 0
					? 20'($urandom) : 20'($urandom_range(1, 3 << 16))));
				random_pixels(28);
				drain();
			end
		end
		$display("Run covered %0d pixels in, %0d out, all tone modes and register extremes.",
			pixels_in, pixels_out);
		$display("Stall phases of both sides and a long output hold-off were exercised.");
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
